// ----- hw/rtl/bsp_pkg.sv -----
// Shared types and constants for the bounded stack with producer pacing.
package bsp_pkg;

    localparam int DATA_W     = 32;
    localparam int PERIOD_W   = 16;
    localparam int WAIT_W     = 32;
    localparam int OCC_W      = 7;
    localparam int MARK_W     = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [PERIOD_W-1:0] PERIOD_INIT_RESET = 16'd100;
    localparam logic [MARK_W-1:0]   LOW_MARK_RESET    = 7'd16;
    localparam logic [MARK_W-1:0]   HIGH_MARK_RESET   = 7'd48;

    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_POP  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PERIOD_INITIAL = 2'd0,
        CFG_LOW_MARK       = 2'd1,
        CFG_HIGH_MARK      = 2'd2
    } bsp_cfg_reg_t;

    // What one taken request looks like to the pacing/statistics unit.
    typedef struct packed {
        logic push;
        logic pop;
        logic empty;
        logic full;
        logic at_low;
        logic at_high;
    } bsp_event_t;

    // Pacing period and wait counters after a request.
    typedef struct packed {
        logic [PERIOD_W-1:0] period;
        logic [WAIT_W-1:0]   full_waits;
        logic [WAIT_W-1:0]   empty_waits;
    } bsp_stats_t;

endpackage

// ----- hw/rtl/bounded_stack_with_producer_pacing.sv -----
// Top level: bounded LIFO stack with producer pacing period and wait counters.
//
// Each request is a push (mode 0) or a pop of the newest entry (mode 1) and
// produces exactly one result. Sustained rate is one request per clock while
// rsp_stall does not back up the pipeline; a result reaches the rsp side
// through the registered read of the entry store and then the output
// register. The output register lets a new request enter while a finished
// result is still stalled; req_stall rises only when both the read stage and
// the output register are occupied and rsp_stall is high. A push first
// adjusts the pacing period (reload to period_initial/2 when empty, step down
// at or below low_mark, step up at or above high_mark); a push to a full stack
// or a pop from an empty one is rejected and bumps a saturating counter.
// Entry store contents are undefined after reset; no clearing pass is run.
// Configuration writes take effect at the next clock and are meant for idle
// periods; writing period_initial does not disturb the current period.
module bounded_stack_with_producer_pacing
    import bsp_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    // configuration
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    // request channel
    input  logic                     req_valid,
    output logic                     req_stall,
    input  logic                     mode,
    input  logic signed [DATA_W-1:0] push_value,
    // result channel
    output logic                     rsp_valid,
    input  logic                     rsp_stall,
    output logic                     accepted,
    output logic signed [DATA_W-1:0] pop_value,
    output logic [OCC_W-1:0]         occupancy,
    output logic [PERIOD_W-1:0]      producer_period,
    output logic [WAIT_W-1:0]        full_waits,
    output logic [WAIT_W-1:0]        empty_waits
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > MARK_W) ? CW : MARK_W;

    // ---------------- configuration ----------------
    logic [PERIOD_W-1:0] period_initial_reg;
    logic [MARK_W-1:0]   low_mark_reg;
    logic [MARK_W-1:0]   high_mark_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_initial_reg <= PERIOD_INIT_RESET;
            low_mark_reg       <= LOW_MARK_RESET;
            high_mark_reg      <= HIGH_MARK_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PERIOD_INITIAL: period_initial_reg <= cfg_data[PERIOD_W-1:0];
                CFG_LOW_MARK:       low_mark_reg       <= cfg_data[MARK_W-1:0];
                CFG_HIGH_MARK:      high_mark_reg      <= cfg_data[MARK_W-1:0];
                default:            ;   // unused index, write dropped
            endcase
        end
    end

    // ---------------- handshake / pipeline control ----------------
    logic s1_valid_reg;
    logic out_valid_reg;
    logic out_ready;
    logic s1_move;
    logic s1_ready;
    logic req_fire;

    assign out_ready = !out_valid_reg || !rsp_stall;
    assign s1_move   = s1_valid_reg && out_ready;
    assign s1_ready  = !s1_valid_reg || s1_move;
    assign req_stall = !s1_ready;
    assign req_fire  = req_valid && s1_ready;

    // ---------------- stack pointer and request decode ----------------
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic [CMPW-1:0] count_cmp;
    logic            is_empty;
    logic            is_full;
    logic            push_ok;
    logic            pop_ok;
    bsp_event_t      ev;
    bsp_stats_t      stats_next;

    assign count_cmp = CMPW'(count_reg);
    assign is_empty  = (count_reg == '0);
    assign is_full   = (count_reg == CW'(DEPTH));
    assign push_ok   = (mode == MODE_PUSH) && !is_full;
    assign pop_ok    = (mode == MODE_POP) && !is_empty;

    assign ev = '{
        push:    (mode == MODE_PUSH),
        pop:     (mode == MODE_POP),
        empty:   is_empty,
        full:    is_full,
        at_low:  (count_cmp <= CMPW'(low_mark_reg)),
        at_high: (count_cmp >= CMPW'(high_mark_reg))
    };

    always_comb
    begin
        count_next = count_reg;
        if (push_ok)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop_ok)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (req_fire)
        begin
            count_reg <= count_next;
        end
    end

    bsp_pace u_pace (
        .clk            (clk),
        .rst_n          (rst_n),
        .period_initial (period_initial_reg),
        .fire           (req_fire),
        .ev             (ev),
        .stats_next     (stats_next)
    );

    // ---------------- entry store: write top on push, read top on pop ----------------
    // A pop reads the slot a push of the previous cycle wrote, after that write
    // has landed, so no bypass is needed.
    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;
    logic [CW-1:0]     pop_addr;

    assign pop_addr = count_reg - CW'(1);

    always_ff @(posedge clk)
    begin
        if (req_fire && push_ok)
        begin
            mem[count_reg[AW-1:0]] <= push_value;
        end
        if (req_fire && pop_ok)
        begin
            rdata_reg <= mem[pop_addr[AW-1:0]];
        end
    end

    // ---------------- stage 1: waits on the store read ----------------
    logic             s1_acc_reg;
    logic             s1_pop_reg;
    logic [OCC_W-1:0] s1_occ_reg;
    bsp_stats_t       s1_stats_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= req_fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            s1_acc_reg   <= push_ok || pop_ok;
            s1_pop_reg   <= pop_ok;
            s1_occ_reg   <= OCC_W'(count_next);
            s1_stats_reg <= stats_next;
        end
    end

    // ---------------- output register ----------------
    logic                     acc_reg;
    logic signed [DATA_W-1:0] pop_value_reg;
    logic [OCC_W-1:0]         occ_reg;
    bsp_stats_t               stats_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            acc_reg       <= s1_acc_reg;
            pop_value_reg <= s1_pop_reg ? rdata_reg : '0;
            occ_reg       <= s1_occ_reg;
            stats_reg     <= s1_stats_reg;
        end
    end

    assign rsp_valid       = out_valid_reg;
    assign accepted        = acc_reg;
    assign pop_value       = pop_value_reg;
    assign occupancy       = occ_reg;
    assign producer_period = stats_reg.period;
    assign full_waits      = stats_reg.full_waits;
    assign empty_waits     = stats_reg.empty_waits;

    // ---------------- assertions ----------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("stack pointer beyond depth");

    a_stall_only_when_full_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> (s1_valid_reg && out_valid_reg && rsp_stall))
        else $error("request stalled with room in the pipeline");

    a_out_from_s1: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg))
        else $error("result appeared without a request in flight");

    a_full_push_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && mode == MODE_PUSH && is_full) |=> (count_reg == CW'(DEPTH)))
        else $error("rejected push changed the stack pointer");

endmodule

// ----- hw/rtl/bsp_pace.sv -----
// Producer pacing period and saturating wait counters.
module bsp_pace
    import bsp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [PERIOD_W-1:0] period_initial,
    input  logic                fire,
    input  bsp_event_t          ev,
    output bsp_stats_t          stats_next
);

    logic [PERIOD_W-1:0] period_reg;
    logic [PERIOD_W-1:0] period_next;
    logic [WAIT_W-1:0]   full_reg;
    logic [WAIT_W-1:0]   full_next;
    logic [WAIT_W-1:0]   empty_reg;
    logic [WAIT_W-1:0]   empty_next;
    logic [PERIOD_W-1:0] half;

    assign half = {1'b0, period_initial[PERIOD_W-1:1]};

    always_comb
    begin
        period_next = period_reg;
        if (ev.push)
        begin
            if (ev.empty)
            begin
                // reload, never below one
                period_next = (half == '0) ? PERIOD_W'(1) : half;
            end
            else if (ev.at_low && period_reg > PERIOD_W'(1))
            begin
                period_next = period_reg - PERIOD_W'(1);
            end
            else if (ev.at_high && period_reg != '0)
            begin
                if (period_reg != '1)
                begin
                    period_next = period_reg + PERIOD_W'(1);
                end
            end
        end
    end

    always_comb
    begin
        full_next  = full_reg;
        empty_next = empty_reg;
        if (ev.push && ev.full && full_reg != '1)
        begin
            full_next = full_reg + WAIT_W'(1);
        end
        if (ev.pop && ev.empty && empty_reg != '1)
        begin
            empty_next = empty_reg + WAIT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_INIT_RESET;
            full_reg   <= '0;
            empty_reg  <= '0;
        end
        else if (fire)
        begin
            period_reg <= period_next;
            full_reg   <= full_next;
            empty_reg  <= empty_next;
        end
    end

    assign stats_next = '{period: period_next, full_waits: full_next, empty_waits: empty_next};

endmodule
